// ===== hw/rtl/xrb_pkg.sv =====
`timescale 1ns / 1ps

package xrb_pkg;

  localparam int unsigned GP_COUNT  = 8;
  localparam int unsigned SEG_COUNT = 6;
  localparam int unsigned GP_AW     = $clog2(GP_COUNT);
  localparam int unsigned SEG_AW    = $clog2(SEG_COUNT);

  typedef enum logic [2:0] {
    CMD_GP_RD   = 3'd0,
    CMD_GP_WR   = 3'd1,
    CMD_FLAG_RD = 3'd2,
    CMD_FLAG_WR = 3'd3,
    CMD_SEG_RD  = 3'd4,
    CMD_SEG_WR  = 3'd5,
    CMD_IP_RD   = 3'd6,
    CMD_IP_WR   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_e;

  localparam logic [63:0] GP_RESET [GP_COUNT] = '{
    64'hbf8db144, 64'h88c5cffb, 64'h1,       64'hae5ff4,
    64'hbf8db0bc, 64'hbf8db118, 64'h9a0ca0,  64'h0
  };

  localparam logic [15:0] SEG_RESET [SEG_COUNT] = '{
    16'h73, 16'h7b, 16'h7b, 16'h7b, 16'h0, 16'h33
  };

  localparam logic [63:0] IP_RESET = 64'h8048354;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  reg_index;
    size_e       size;
    logic [63:0] data;
    logic [4:0]  flag_bit;
    logic        flag_value;
  } req_t;

  typedef struct packed {
    logic [63:0] prev;
    logic        gp_we;
    logic [63:0] gp_wdata;
    logic        seg_we;
    logic [15:0] seg_wdata;
    logic [63:0] ip_d;
    logic [31:0] flags_d;
  } res_t;

endpackage

// ===== hw/rtl/x86_register_bank.sv =====
`timescale 1ns / 1ps

// Emulated x86 register bank: eight 64-bit general registers, six 16-bit
// segment registers, a 64-bit instruction pointer and a 32-bit flags word.
// Every input beat is one access, a read or a write chosen by cmd, and
// yields exactly one output beat that carries the value before the access,
// zero-extended to 64 bits. The block sustains one access per cycle while
// its output is not stalled. The register memories have a registered read
// port; they are read when a beat is taken and written back when that beat
// retires from the execute stage, which a stall can hold. A write followed
// at once by an access to the same register is served by forwarding the
// written value. After reset every register holds its start value at once
// (per-entry valid bits stand in for the memory contents), so no clearing
// pass is needed. A finished result waits in an output register, and the
// next beat is still taken while it waits; only when that register is full
// and stalled does the input stall too.
module x86_register_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  reg_index_i,
  input  logic [1:0]  access_size_i,
  input  logic [63:0] write_data_i,
  input  logic [4:0]  flag_bit_i,
  input  logic        flag_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_data_o
);

  localparam int unsigned GpAw  = xrb_pkg::GP_AW;
  localparam int unsigned SegAw = xrb_pkg::SEG_AW;

  xrb_pkg::req_t req_in;
  xrb_pkg::req_t req_q;
  xrb_pkg::res_t res;

  logic             accept;
  logic             done;
  logic             busy_q;
  logic             busy_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic [63:0]      read_data_q;

  logic [GpAw-1:0]  gp_raddr;
  logic [GpAw-1:0]  gp_addr_q;
  logic [SegAw-1:0] seg_addr_q;
  logic             seg_re;
  logic [63:0]      gp_rdata;
  logic [15:0]      seg_rdata;
  logic [63:0]      gp_old;
  logic [15:0]      seg_old;

  logic             gp_fwd_q;
  logic [63:0]      gp_fwd_data_q;
  logic             seg_fwd_q;
  logic [15:0]      seg_fwd_data_q;

  logic [xrb_pkg::GP_COUNT-1:0]  gp_valid_q;
  logic [xrb_pkg::SEG_COUNT-1:0] seg_valid_q;

  logic [63:0]      ip_q;
  logic [31:0]      flags_q;

  assign req_in.cmd        = xrb_pkg::cmd_e'(cmd_i);
  assign req_in.reg_index  = reg_index_i;
  assign req_in.size       = xrb_pkg::size_e'(access_size_i);
  assign req_in.data       = write_data_i;
  assign req_in.flag_bit   = flag_bit_i;
  assign req_in.flag_value = flag_value_i;

  // The item in the execute stage retires when the output register is free
  // or is being emptied in this cycle.
  assign done       = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  // Byte accesses to indices four to seven reach the high byte of
  // registers zero to three.
  assign gp_raddr = (req_in.size == xrb_pkg::SIZE_8) ? {1'b0, reg_index_i[1:0]} : reg_index_i;
  assign seg_re   = accept && (reg_index_i < 3'(xrb_pkg::SEG_COUNT));

  xrb_ram #(
    .DEPTH (xrb_pkg::GP_COUNT),
    .WIDTH (64)
  ) u_gp_ram (
    .clk_i   (clk_i),
    .we_i    (done && res.gp_we),
    .waddr_i (gp_addr_q),
    .wdata_i (res.gp_wdata),
    .re_i    (accept),
    .raddr_i (gp_raddr),
    .rdata_o (gp_rdata)
  );

  xrb_ram #(
    .DEPTH (xrb_pkg::SEG_COUNT),
    .WIDTH (16)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (done && res.seg_we),
    .waddr_i (seg_addr_q),
    .wdata_i (res.seg_wdata),
    .re_i    (seg_re),
    .raddr_i (reg_index_i[SegAw-1:0]),
    .rdata_o (seg_rdata)
  );

  // A forwarded value wins over the memory, and an entry that was never
  // written since reset reads as its start value.
  always_comb begin
    if (gp_fwd_q) begin
      gp_old = gp_fwd_data_q;
    end else if (gp_valid_q[gp_addr_q]) begin
      gp_old = gp_rdata;
    end else begin
      gp_old = xrb_pkg::GP_RESET[gp_addr_q];
    end
  end

  // Segment indices six and seven never reach this value; the execute
  // logic returns zero for them.
  always_comb begin
    if (seg_fwd_q) begin
      seg_old = seg_fwd_data_q;
    end else if (seg_valid_q[seg_addr_q]) begin
      seg_old = seg_rdata;
    end else begin
      seg_old = xrb_pkg::SEG_RESET[seg_addr_q];
    end
  end

  xrb_exec u_exec (
    .req_i     (req_q),
    .gp_old_i  (gp_old),
    .seg_old_i (seg_old),
    .ip_i      (ip_q),
    .flags_i   (flags_q),
    .res_o     (res)
  );

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      gp_fwd_q    <= 1'b0;
      seg_fwd_q   <= 1'b0;
      gp_valid_q  <= '0;
      seg_valid_q <= '0;
      ip_q        <= xrb_pkg::IP_RESET;
      flags_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        // The memory read taken in this cycle misses a write-back at the
        // same edge, so the written value is kept aside for the next stage.
        gp_fwd_q  <= done && res.gp_we && (gp_addr_q == gp_raddr);
        seg_fwd_q <= done && res.seg_we && (seg_addr_q == reg_index_i[SegAw-1:0]);
      end else if (done) begin
        // The execute stage empties, so nothing is left to forward to.
        gp_fwd_q  <= 1'b0;
        seg_fwd_q <= 1'b0;
      end
      if (done) begin
        if (res.gp_we) begin
          gp_valid_q[gp_addr_q] <= 1'b1;
        end
        if (res.seg_we) begin
          seg_valid_q[seg_addr_q] <= 1'b1;
        end
        ip_q    <= res.ip_d;
        flags_q <= res.flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q          <= req_in;
      gp_addr_q      <= gp_raddr;
      seg_addr_q     <= reg_index_i[SegAw-1:0];
      gp_fwd_data_q  <= res.gp_wdata;
      seg_fwd_data_q <= res.seg_wdata;
    end
    if (done) begin
      read_data_q <= res.prev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

`ifndef SYNTHESIS
  a_fwd_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gp_fwd_q || seg_fwd_q) |-> busy_q)
    else $error("forwarded value held with no item in the execute stage");

  a_done_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("retired item did not reach the output register");

  a_gp_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && res.gp_we) |=> gp_valid_q[$past(gp_addr_q)])
    else $error("general register write did not mark its entry valid");

  a_ip_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (req_q.cmd == xrb_pkg::CMD_IP_WR) && (req_q.size == xrb_pkg::SIZE_8))
      |=> $stable(ip_q))
    else $error("byte write changed the instruction pointer");
`endif

endmodule

// ===== hw/rtl/xrb_ram.sv =====
`timescale 1ns / 1ps

module xrb_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/xrb_exec.sv =====
`timescale 1ns / 1ps

module xrb_exec (
  input  xrb_pkg::req_t req_i,
  input  logic [63:0]   gp_old_i,
  input  logic [15:0]   seg_old_i,
  input  logic [63:0]   ip_i,
  input  logic [31:0]   flags_i,
  output xrb_pkg::res_t res_o
);

  logic        byte_hi;
  logic        seg_ok;
  logic [63:0] gp_prev;
  logic [63:0] gp_new;
  logic [63:0] ip_new;
  logic [31:0] flags_new;

  assign byte_hi = req_i.reg_index[2];
  assign seg_ok  = req_i.reg_index < 3'(xrb_pkg::SEG_COUNT);

  // Slice selection and merge for the general registers.
  always_comb begin
    unique case (req_i.size)
      xrb_pkg::SIZE_8: begin
        if (byte_hi) begin
          gp_prev = {56'd0, gp_old_i[15:8]};
          gp_new  = {gp_old_i[63:16], req_i.data[7:0], gp_old_i[7:0]};
        end else begin
          gp_prev = {56'd0, gp_old_i[7:0]};
          gp_new  = {gp_old_i[63:8], req_i.data[7:0]};
        end
      end
      xrb_pkg::SIZE_16: begin
        gp_prev = {48'd0, gp_old_i[15:0]};
        gp_new  = {gp_old_i[63:16], req_i.data[15:0]};
      end
      xrb_pkg::SIZE_32: begin
        gp_prev = {32'd0, gp_old_i[31:0]};
        gp_new  = {gp_old_i[63:32], req_i.data[31:0]};
      end
      default: begin
        gp_prev = gp_old_i;
        gp_new  = req_i.data;
      end
    endcase
  end

  // The pointer has no byte-wide form, so a byte write leaves it alone.
  always_comb begin
    unique case (req_i.size)
      xrb_pkg::SIZE_16: ip_new = {ip_i[63:16], req_i.data[15:0]};
      xrb_pkg::SIZE_32: ip_new = {ip_i[63:32], req_i.data[31:0]};
      xrb_pkg::SIZE_64: ip_new = req_i.data;
      default:          ip_new = ip_i;
    endcase
  end

  always_comb begin
    flags_new                 = flags_i;
    flags_new[req_i.flag_bit] = req_i.flag_value;
  end

  always_comb begin
    res_o.prev      = 64'd0;
    res_o.gp_we     = 1'b0;
    res_o.gp_wdata  = gp_new;
    res_o.seg_we    = 1'b0;
    res_o.seg_wdata = req_i.data[15:0];
    res_o.ip_d      = ip_i;
    res_o.flags_d   = flags_i;
    unique case (req_i.cmd)
      xrb_pkg::CMD_GP_RD: begin
        res_o.prev = gp_prev;
      end
      xrb_pkg::CMD_GP_WR: begin
        res_o.prev  = gp_prev;
        res_o.gp_we = 1'b1;
      end
      xrb_pkg::CMD_FLAG_RD: begin
        res_o.prev = {63'd0, flags_i[req_i.flag_bit]};
      end
      xrb_pkg::CMD_FLAG_WR: begin
        res_o.prev    = {63'd0, flags_i[req_i.flag_bit]};
        res_o.flags_d = flags_new;
      end
      xrb_pkg::CMD_SEG_RD: begin
        res_o.prev = seg_ok ? {48'd0, seg_old_i} : 64'd0;
      end
      xrb_pkg::CMD_SEG_WR: begin
        res_o.prev   = seg_ok ? {48'd0, seg_old_i} : 64'd0;
        res_o.seg_we = seg_ok;
      end
      xrb_pkg::CMD_IP_RD: begin
        res_o.prev = ip_i;
      end
      default: begin
        res_o.prev = ip_i;
        res_o.ip_d = ip_new;
      end
    endcase
  end

endmodule

// ===== tb/tb_x86_register_bank.sv =====
`timescale 1ns / 1ps

// Testbench for the emulated x86 register bank.
//
// An initial block builds the whole list of accesses up front: a short
// directed list that touches every command, every access size, the high
// byte registers, the unused segment slots, the 8-bit pointer write that
// has no effect and the flag bits above the architected ones. A long random
// list follows. A clocked driver feeds those accesses to the block one beat
// at a time. At every accepted input beat it runs the access through a
// behavioral copy of the register bank and queues the prior value that the
// block must return. A clocked monitor takes output beats and checks each
// one against the oldest queued value.
//
// The run is split into four load phases by the number of beats issued. The
// first has no idling at all. In the second the sender idles, in the third
// the receiver stalls, and in the fourth both do so at a lower rate. The
// random list reuses the previous register index often, so that a write is
// frequently followed at once by an access to the same register. This
// exercises the block's forwarding path.
module tb_x86_register_bank;

  import xrb_pkg::*;

  // Clock period is 2 ns, so the limit below is counted in cycles.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned RANDOM_BEATS  = 1650;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned IDLE_HEAVY    = 73;
  localparam int unsigned IDLE_MIXED    = 35;

  // General register numbers in x86 encoding order. For byte accesses the
  // indexes four to seven name the high bytes of the first four registers.
  localparam logic [2:0] REG_AX = 3'd0;
  localparam logic [2:0] REG_CX = 3'd1;
  localparam logic [2:0] REG_DX = 3'd2;
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_AH = 3'd4;
  localparam logic [2:0] REG_CH = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;
  localparam logic [2:0] REG_BH = 3'd7;

  // Segment register numbers. Slots six and seven do not exist.
  localparam logic [2:0] SEG_CS    = 3'd0;
  localparam logic [2:0] SEG_GS    = 3'd5;
  localparam logic [2:0] SEG_NONE6 = 3'd6;
  localparam logic [2:0] SEG_NONE7 = 3'd7;

  // Flag bit positions: carry, the highest architected flag (ID), and the
  // top bit of the flags word.
  localparam logic [4:0] FLAG_CF  = 5'd0;
  localparam logic [4:0] FLAG_ID  = 5'd21;
  localparam logic [4:0] FLAG_TOP = 5'd31;

  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    LOAD_FREE,
    LOAD_SEND_IDLE,
    LOAD_RECV_STALL,
    LOAD_BOTH
  } load_phase_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i;
  logic [2:0]  reg_index_i;
  logic [1:0]  access_size_i;
  logic [63:0] write_data_i;
  logic [4:0]  flag_bit_i;
  logic        flag_value_i;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [63:0] read_data_o;

  // The access on the input bus. Every payload port follows it, so all of
  // them hold a known value from time zero on.
  req_t drv_beat = '0;

  assign cmd_i         = drv_beat.cmd;
  assign reg_index_i   = drv_beat.reg_index;
  assign access_size_i = drv_beat.size;
  assign write_data_i  = drv_beat.data;
  assign flag_bit_i    = drv_beat.flag_bit;
  assign flag_value_i  = drv_beat.flag_value;

  req_t        access_backlog [$];
  logic [63:0] prior_values_due [$];

  int unsigned total_beats    = 0;
  int unsigned beats_issued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Behavioral copy of the register bank, updated once per accepted beat.
  logic [63:0] gp_model  [GP_COUNT];
  logic [15:0] seg_model [SEG_COUNT];
  logic [63:0] ip_model;
  logic [31:0] flags_model;

  x86_register_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .reg_index_i   (reg_index_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .flag_bit_i    (flag_bit_i),
    .flag_value_i  (flag_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Performs one access on the behavioral bank and returns the value that
  // the selected register or slice held before it, zero-extended.
  function automatic logic [63:0] access_prior_value(req_t b);
    logic [63:0] prior;
    logic [1:0]  low_reg;
    prior   = '0;
    low_reg = b.reg_index[1:0];
    case (b.cmd)
      CMD_GP_RD, CMD_GP_WR: begin
        case (b.size)
          SIZE_8: begin
            if (b.reg_index[2]) begin
              prior = {56'd0, gp_model[low_reg][15:8]};
            end else begin
              prior = {56'd0, gp_model[low_reg][7:0]};
            end
          end
          SIZE_16: prior = {48'd0, gp_model[b.reg_index][15:0]};
          SIZE_32: prior = {32'd0, gp_model[b.reg_index][31:0]};
          default: prior = gp_model[b.reg_index];
        endcase
        if (b.cmd == CMD_GP_WR) begin
          case (b.size)
            SIZE_8: begin
              if (b.reg_index[2]) begin
                gp_model[low_reg][15:8] = b.data[7:0];
              end else begin
                gp_model[low_reg][7:0] = b.data[7:0];
              end
            end
            SIZE_16: gp_model[b.reg_index][15:0] = b.data[15:0];
            SIZE_32: gp_model[b.reg_index][31:0] = b.data[31:0];
            default: gp_model[b.reg_index] = b.data;
          endcase
        end
      end
      CMD_FLAG_RD, CMD_FLAG_WR: begin
        prior = {63'd0, flags_model[b.flag_bit]};
        if (b.cmd == CMD_FLAG_WR) begin
          flags_model[b.flag_bit] = b.flag_value;
        end
      end
      CMD_SEG_RD, CMD_SEG_WR: begin
        // The missing slots read as zero and swallow writes.
        if (b.reg_index < SEG_COUNT) begin
          prior = {48'd0, seg_model[b.reg_index]};
          if (b.cmd == CMD_SEG_WR) begin
            seg_model[b.reg_index] = b.data[15:0];
          end
        end
      end
      default: begin
        // The pointer always returns its full width. A byte-sized write
        // has no x86 form and leaves the pointer alone.
        prior = ip_model;
        if (b.cmd == CMD_IP_WR) begin
          case (b.size)
            SIZE_16: ip_model[15:0] = b.data[15:0];
            SIZE_32: ip_model[31:0] = b.data[31:0];
            SIZE_64: ip_model = b.data;
            default: ;
          endcase
        end
      end
    endcase
    return prior;
  endfunction

  function automatic req_t make_beat(cmd_e c, logic [2:0] idx, size_e sz,
                                     logic [63:0] d, logic [4:0] fb, logic fv);
    req_t b;
    b.cmd        = c;
    b.reg_index  = idx;
    b.size       = sz;
    b.data       = d;
    b.flag_bit   = fb;
    b.flag_value = fv;
    return b;
  endfunction

  // Appends one access to the end of the pending list.
  function automatic void queue_access(req_t b);
    access_backlog.insert(access_backlog.size(), b);
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    case ($urandom_range(5))
      0: w = '0;
      1: w = ALL_ONES;
      2: w = {56'd0, 8'($urandom)};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // The load phase follows the number of beats put on the bus so far.
  function automatic load_phase_e current_phase();
    int unsigned quarter;
    quarter = (total_beats == 0) ? 0 : (beats_issued * 4) / total_beats;
    if (quarter > 3) begin
      quarter = 3;
    end
    return load_phase_e'(quarter);
  endfunction

  function automatic int unsigned send_idle_pct();
    case (current_phase())
      LOAD_SEND_IDLE: return IDLE_HEAVY;
      LOAD_BOTH:      return IDLE_MIXED;
      default:        return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (current_phase())
      LOAD_RECV_STALL: return IDLE_HEAVY;
      LOAD_BOTH:       return IDLE_MIXED;
      default:         return 0;
    endcase
  endfunction

  // Driver. A beat that is stalled stays on the bus unchanged. Otherwise
  // the next access goes out unless this cycle is picked as an idle one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        prior_values_due.insert(prior_values_due.size(), access_prior_value(drv_beat));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (access_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          drv_beat   <= access_backlog.pop_front();
          in_valid_i <= 1'b1;
          beats_issued++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted output beat must match the oldest prior value
  // still owed. Only the first few failures are printed in full.
  always @(posedge clk_i) begin : result_check
    logic [63:0] owed;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (prior_values_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("ERROR: unexpected output beat, read_data %h", read_data_o);
          end
        end else begin
          owed = prior_values_due.pop_front();
          if (read_data_o !== owed) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ERROR: read_data expected %h, got %h", owed, read_data_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]  last_index;
    logic [2:0]  idx;
    logic [63:0] word;

    for (int i = 0; i < GP_COUNT; i++) begin
      gp_model[i] = GP_RESET[i];
    end
    for (int i = 0; i < SEG_COUNT; i++) begin
      seg_model[i] = SEG_RESET[i];
    end
    ip_model    = IP_RESET;
    flags_model = '0;

    // Directed part: the reset values at every size, both byte halves,
    // narrow writes that must keep the upper bits, flags up to the top bit,
    // the missing segment slots and every form of pointer write.
    queue_access(make_beat(CMD_GP_RD, REG_AX, SIZE_8, ALL_ONES, FLAG_TOP, 1'b1));
    queue_access(make_beat(CMD_GP_RD, REG_AH, SIZE_8, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_BH, SIZE_8, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_CX, SIZE_16, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_DX, SIZE_32, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_BX, SIZE_64, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_AX, SIZE_64, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_AX, SIZE_8, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_AH, SIZE_8, 64'h5a, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_CH, SIZE_8, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_AX, SIZE_64, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_SI, SIZE_16, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_WR, REG_DI, SIZE_32, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_GP_RD, REG_DI, SIZE_64, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_FLAG_WR, REG_AX, SIZE_8, '0, FLAG_CF, 1'b1));
    queue_access(make_beat(CMD_FLAG_WR, REG_AX, SIZE_8, '0, FLAG_ID, 1'b1));
    queue_access(make_beat(CMD_FLAG_WR, REG_AX, SIZE_8, '0, FLAG_TOP, 1'b1));
    queue_access(make_beat(CMD_FLAG_RD, REG_AX, SIZE_8, '0, FLAG_TOP, 1'b0));
    queue_access(make_beat(CMD_FLAG_WR, REG_AX, SIZE_8, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_SEG_RD, SEG_CS, SIZE_16, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_SEG_WR, SEG_GS, SIZE_16, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_SEG_RD, SEG_GS, SIZE_16, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_SEG_RD, SEG_NONE6, SIZE_16, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_SEG_WR, SEG_NONE7, SIZE_16, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_IP_WR, REG_AX, SIZE_8, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_IP_WR, REG_AX, SIZE_16, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_IP_WR, REG_AX, SIZE_32, ALL_ONES, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_IP_WR, REG_AX, SIZE_64, '0, FLAG_CF, 1'b0));
    queue_access(make_beat(CMD_IP_RD, REG_AX, SIZE_8, ALL_ONES, FLAG_CF, 1'b0));

    // Random part. Every field is random on every beat, unused ones too.
    // Reusing the previous index half of the time gives many back-to-back
    // accesses to one register.
    last_index = REG_AX;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      idx        = ($urandom_range(1) == 0) ? last_index : 3'($urandom_range(7));
      last_index = idx;
      word       = random_word();
      queue_access(make_beat(cmd_e'($urandom_range(7)), idx,
                             size_e'($urandom_range(3)), word,
                             5'($urandom_range(31)), 1'($urandom)));
    end
    total_beats = access_backlog.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every access has been taken and answered, then let the clock
    // run on so that any stray output beat from the block can show.
    while (access_backlog.size() != 0 || in_valid_i || prior_values_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && prior_values_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
